[rtl/sldm_pkg.sv]
// Shared types, constants and microcode for the slew-limited drive mixer.
// Used by the mixer core, its port checker and the testbench; depends on nothing else.
package sldm_pkg;

  localparam int VEL_W   = 16;   // Q3.12 velocity
  localparam int STEP_W  = 15;   // Q3.12 step limit
  localparam int GAIN_W  = 20;   // Q8 signed gain
  localparam int TRIM_W  = 16;   // Q2.14 trim
  localparam int LIM_W   = 10;   // command limit
  localparam int SP_W    = 11;   // setpoint
  localparam int CFG_A_W = 3;
  localparam int CFG_D_W = 20;
  localparam int PROD1_W = GAIN_W + VEL_W;   // gain times velocity
  localparam int MIX_W   = PROD1_W + 1;      // sum or difference of two products
  localparam int PROD_W  = MIX_W + GAIN_W;   // shared multiplier output
  localparam int FRAC_SH = 34;
  localparam int PC_W    = 3;
  localparam int IN_TD_W  = 32;
  localparam int OUT_TD_W = 24;

  localparam logic [STEP_W-1:0]        LIN_STEP_RST = 15'd82;
  localparam logic [STEP_W-1:0]        ANG_STEP_RST = 15'd82;
  localparam logic signed [GAIN_W-1:0] FWD_GAIN_RST = -20'sd163630;
  localparam logic signed [GAIN_W-1:0] TURN_GAIN_RST = 20'sd57352;
  localparam logic [TRIM_W-1:0]        TRIM1_RST = 16'd16433;
  localparam logic [TRIM_W-1:0]        TRIM2_RST = 16'd16335;
  localparam logic [LIM_W-1:0]         CMD_LIM_RST = 10'd721;

  typedef enum logic [CFG_A_W-1:0] {
    REG_LIN_STEP  = 3'd0,
    REG_ANG_STEP  = 3'd1,
    REG_FWD_GAIN  = 3'd2,
    REG_TURN_GAIN = 3'd3,
    REG_TRIM1     = 3'd4,
    REG_TRIM2     = 3'd5,
    REG_CMD_LIM   = 3'd6
  } reg_idx_t;

  typedef enum logic [2:0] {
    OP_WAIT,
    OP_SLEW,
    OP_MUL_BASE,
    OP_MUL_TURN,
    OP_MIX,
    OP_MUL_CH1,
    OP_MUL_CH2,
    OP_EMIT
  } uop_t;

  // Hold conditions: while the condition is true the step repeats.
  typedef enum logic [1:0] {
    HOLD_NONE,
    HOLD_NO_IN,
    HOLD_OUT_BUSY
  } hold_t;

  typedef struct packed {
    uop_t            op;
    hold_t           hold;
    logic [PC_W-1:0] target;
  } uword_t;

  function automatic uword_t ucode(input logic [PC_W-1:0] pc);
    uword_t w;
    case (pc)
      3'd0:    w = '{op: OP_WAIT,     hold: HOLD_NO_IN,    target: 3'd1};
      3'd1:    w = '{op: OP_SLEW,     hold: HOLD_NONE,     target: 3'd2};
      3'd2:    w = '{op: OP_MUL_BASE, hold: HOLD_NONE,     target: 3'd3};
      3'd3:    w = '{op: OP_MUL_TURN, hold: HOLD_NONE,     target: 3'd4};
      3'd4:    w = '{op: OP_MIX,      hold: HOLD_NONE,     target: 3'd5};
      3'd5:    w = '{op: OP_MUL_CH1,  hold: HOLD_NONE,     target: 3'd6};
      3'd6:    w = '{op: OP_MUL_CH2,  hold: HOLD_NONE,     target: 3'd7};
      3'd7:    w = '{op: OP_EMIT,     hold: HOLD_OUT_BUSY, target: 3'd0};
      default: w = '{op: OP_WAIT,     hold: HOLD_NONE,     target: 3'd0};
    endcase
    return w;
  endfunction

endpackage

[rtl/slew_limited_diff_drive_mixer_core.sv]
// Slew-limited differential drive mixer, microcoded over one shared multiplier.
// Depends on sldm_pkg for widths, register indexes and the microcode table.
//
//  channel  | direction | tdata / fields (low bit first)              | tuser
//  in_      | slave     | target_linear[15:0], target_angular[31:16]  | none
//  out_     | master    | channel1_setpoint[10:0], channel2_setpoint[21:11], pad | none
//  cfg_     | write     | cfg_addr selects a register, cfg_wdata holds it | none
//
// Each word passes the slew, base, turn, mix and channel steps to the output register, and
// the input reopens in the cycle after that load, so a new word is taken only once the last is loaded.
// The sequence is set by the shared 37x20 multiplier, used four times per word.
// If the output register still holds an untaken result, the last step waits.
// Reset (rst_n low, synchronous) restores the register defaults and clears
// the stored velocities and the output valid.
module slew_limited_diff_drive_mixer_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [sldm_pkg::IN_TD_W-1:0]    in_tdata,   // target_linear, target_angular
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [sldm_pkg::OUT_TD_W-1:0]   out_tdata,  // channel1_setpoint, channel2_setpoint, zeros
  input  logic                            cfg_we,
  input  logic [sldm_pkg::CFG_A_W-1:0]    cfg_addr,
  input  logic [sldm_pkg::CFG_D_W-1:0]    cfg_wdata
);

  localparam int VW = sldm_pkg::VEL_W;
  localparam int PW = sldm_pkg::PROD_W;
  localparam logic signed [PW-1:0] RND_HALF = PW'(64'd1 << (sldm_pkg::FRAC_SH - 1));

  // Configuration registers.
  logic [sldm_pkg::STEP_W-1:0]        lin_step_r, ang_step_r;
  logic signed [sldm_pkg::GAIN_W-1:0] fwd_gain_r, turn_gain_r;
  logic [sldm_pkg::TRIM_W-1:0]        trim1_r, trim2_r;
  logic [sldm_pkg::LIM_W-1:0]         cmd_lim_r;

  // Sequencer and datapath.
  logic [sldm_pkg::PC_W-1:0]          pc_r, pc_nxt;
  sldm_pkg::uword_t                   uw;
  logic                               hold;
  logic signed [VW-1:0]               tgt_lin_r, tgt_ang_r;
  logic signed [VW-1:0]               last_lin_r, last_ang_r;
  logic signed [VW-1:0]               lin_nxt, ang_nxt;
  logic signed [sldm_pkg::PROD1_W-1:0] base_r;
  logic signed [sldm_pkg::MIX_W-1:0]  mix1_r, mix2_r;
  logic signed [sldm_pkg::MIX_W-1:0]  mul_a;
  logic signed [sldm_pkg::GAIN_W-1:0] mul_b;
  logic signed [PW-1:0]               prod_r, prod_nxt;
  logic signed [sldm_pkg::SP_W-1:0]   ch1_r, sp_now;
  logic signed [sldm_pkg::SP_W-1:0]   out_ch1_r, out_ch2_r;
  logic                               out_valid_r;
  logic                               in_acc, emit;

  function automatic logic signed [VW-1:0] slew(
    input logic signed [VW-1:0] tgt,
    input logic signed [VW-1:0] last,
    input logic [sldm_pkg::STEP_W-1:0] step
  );
    logic signed [VW:0] diff, stp;
    logic signed [VW-1:0] res;
    diff = (VW+1)'(tgt) - (VW+1)'(last);
    stp  = signed'({2'b00, step});
    if (diff > stp) begin
      res = VW'(last + signed'({1'b0, step}));
    end else if (diff < -stp) begin
      res = VW'(last - signed'({1'b0, step}));
    end else begin
      res = tgt;
    end
    return res;
  endfunction

  // Round to nearest (ties upward), then clamp to +/- the command limit.
  function automatic logic signed [sldm_pkg::SP_W-1:0] rnd_clamp(
    input logic signed [PW-1:0] p,
    input logic [sldm_pkg::LIM_W-1:0] lim
  );
    logic signed [PW-1:0] s;
    logic signed [PW-sldm_pkg::FRAC_SH-1:0] r, hi;
    logic signed [sldm_pkg::SP_W-1:0] res;
    s  = p + RND_HALF;
    r  = s[PW-1:sldm_pkg::FRAC_SH];
    hi = signed'((PW-sldm_pkg::FRAC_SH)'(lim));
    if (r > hi) begin
      res = sldm_pkg::SP_W'(hi);
    end else if (r < -hi) begin
      res = sldm_pkg::SP_W'(-hi);
    end else begin
      res = sldm_pkg::SP_W'(r);
    end
    return res;
  endfunction

  assign uw        = sldm_pkg::ucode(pc_r);
  assign in_tready = (uw.op == sldm_pkg::OP_WAIT);
  assign in_acc    = in_tvalid && in_tready;
  assign emit      = (uw.op == sldm_pkg::OP_EMIT) && (!out_valid_r || out_tready);

  always_comb begin
    case (uw.hold)
      sldm_pkg::HOLD_NO_IN:    hold = !in_tvalid;
      sldm_pkg::HOLD_OUT_BUSY: hold = out_valid_r && !out_tready;
      default:                 hold = 1'b0;
    endcase
    pc_nxt = hold ? pc_r : uw.target;
  end

  assign lin_nxt = slew(tgt_lin_r, last_lin_r, lin_step_r);
  assign ang_nxt = slew(tgt_ang_r, last_ang_r, ang_step_r);

  // Operand selection for the shared multiplier.
  always_comb begin
    case (uw.op)
      sldm_pkg::OP_MUL_BASE: begin
        mul_a = sldm_pkg::MIX_W'(last_lin_r);
        mul_b = fwd_gain_r;
      end
      sldm_pkg::OP_MUL_TURN: begin
        mul_a = sldm_pkg::MIX_W'(last_ang_r);
        mul_b = turn_gain_r;
      end
      sldm_pkg::OP_MUL_CH1: begin
        mul_a = mix1_r;
        mul_b = signed'(sldm_pkg::GAIN_W'(trim1_r));
      end
      sldm_pkg::OP_MUL_CH2: begin
        mul_a = mix2_r;
        mul_b = signed'(sldm_pkg::GAIN_W'(trim2_r));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod_nxt = mul_a * mul_b;
  end

  assign sp_now = rnd_clamp(prod_r, cmd_lim_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lin_step_r  <= sldm_pkg::LIN_STEP_RST;
      ang_step_r  <= sldm_pkg::ANG_STEP_RST;
      fwd_gain_r  <= sldm_pkg::FWD_GAIN_RST;
      turn_gain_r <= sldm_pkg::TURN_GAIN_RST;
      trim1_r     <= sldm_pkg::TRIM1_RST;
      trim2_r     <= sldm_pkg::TRIM2_RST;
      cmd_lim_r   <= sldm_pkg::CMD_LIM_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        sldm_pkg::REG_LIN_STEP:  lin_step_r  <= cfg_wdata[sldm_pkg::STEP_W-1:0];
        sldm_pkg::REG_ANG_STEP:  ang_step_r  <= cfg_wdata[sldm_pkg::STEP_W-1:0];
        sldm_pkg::REG_FWD_GAIN:  fwd_gain_r  <= signed'(cfg_wdata);
        sldm_pkg::REG_TURN_GAIN: turn_gain_r <= signed'(cfg_wdata);
        sldm_pkg::REG_TRIM1:     trim1_r     <= cfg_wdata[sldm_pkg::TRIM_W-1:0];
        sldm_pkg::REG_TRIM2:     trim2_r     <= cfg_wdata[sldm_pkg::TRIM_W-1:0];
        sldm_pkg::REG_CMD_LIM:   cmd_lim_r   <= cfg_wdata[sldm_pkg::LIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= '0;
      last_lin_r  <= '0;
      last_ang_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pc_r <= pc_nxt;
      if (uw.op == sldm_pkg::OP_SLEW) begin
        last_lin_r <= lin_nxt;
        last_ang_r <= ang_nxt;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      tgt_lin_r <= signed'(in_tdata[VW-1:0]);
      tgt_ang_r <= signed'(in_tdata[2*VW-1:VW]);
    end
    // The channel two product must survive while the last step waits.
    if (!hold) begin
      prod_r <= prod_nxt;
    end
    if (uw.op == sldm_pkg::OP_MUL_TURN) begin
      base_r <= prod_r[sldm_pkg::PROD1_W-1:0];
    end
    if (uw.op == sldm_pkg::OP_MIX) begin
      mix1_r <= sldm_pkg::MIX_W'(base_r) - prod_r[sldm_pkg::MIX_W-1:0];
      mix2_r <= sldm_pkg::MIX_W'(base_r) + prod_r[sldm_pkg::MIX_W-1:0];
    end
    if (uw.op == sldm_pkg::OP_MUL_CH2) begin
      ch1_r <= sp_now;
    end
    if (emit) begin
      out_ch1_r <= ch1_r;
      out_ch2_r <= sp_now;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, 1'b0, out_ch2_r, out_ch1_r};

endmodule

[rtl/sldm_checker.sv]
// Port-level checker for the slew-limited drive mixer core, bound to the top.
// Depends on sldm_pkg for the port widths.
module sldm_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [sldm_pkg::OUT_TD_W-1:0]   out_tdata
);

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed while stalled");

  // One word at a time: the input closes right after an acceptance.
  a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken twice in a row");

  // A new result only comes out of the final step, while the input is closed.
  a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(!in_tready))
    else $error("result appeared while idle");

  // Clamping keeps both setpoints off the most negative code.
  a_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[10:0] != 11'h400) && (out_tdata[21:11] != 11'h400))
    else $error("setpoint outside clamp range");

endmodule

bind slew_limited_diff_drive_mixer_core sldm_checker u_sldm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

[verif/testbench.sv]
// Self-checking testbench for the slew-limited differential drive mixer core.
// Needs sldm_pkg and slew_limited_diff_drive_mixer_core; predicts every setpoint pair in place.
`timescale 1ns / 1ps

module testbench;

  localparam logic [sldm_pkg::CFG_A_W-1:0] REG_UNUSED = 3'd7;  // no register behind this index
  localparam int STALL_LIMIT     = 2000;
  localparam int SETTLE_CYCLES   = 12;
  localparam int PHASES          = 10;
  localparam int WORDS_PER_PHASE = 115;
  localparam int CHOKE_CYCLES    = 80;

  typedef struct {
    logic signed [sldm_pkg::SP_W-1:0] ch1;
    logic signed [sldm_pkg::SP_W-1:0] ch2;
  } setpoints_t;

  typedef struct {
    bit                                is_cfg;
    logic [sldm_pkg::CFG_A_W-1:0]      addr;
    logic [sldm_pkg::CFG_D_W-1:0]      value;
    logic signed [sldm_pkg::VEL_W-1:0] tl;
    logic signed [sldm_pkg::VEL_W-1:0] ta;
    bit                                typed;
    logic signed [sldm_pkg::SP_W-1:0]  e1;
    logic signed [sldm_pkg::SP_W-1:0]  e2;
  } plan_row_t;

  logic                             clk = 1'b0;
  logic                             rst_n;
  logic                             in_tvalid;
  logic                             in_tready;
  logic [sldm_pkg::IN_TD_W-1:0]     in_tdata;   // target_linear[15:0], target_angular[31:16]
  logic                             out_tvalid;
  logic                             out_tready;
  logic [sldm_pkg::OUT_TD_W-1:0]    out_tdata;  // channel1_setpoint[10:0], channel2_setpoint[21:11], zeros
  logic                             cfg_we;
  logic [sldm_pkg::CFG_A_W-1:0]     cfg_addr;
  logic [sldm_pkg::CFG_D_W-1:0]     cfg_wdata;

  // Mirror of the block's registers and stored velocities.
  logic [sldm_pkg::STEP_W-1:0]        lin_step;
  logic [sldm_pkg::STEP_W-1:0]        ang_step;
  logic signed [sldm_pkg::GAIN_W-1:0] fwd_gain;
  logic signed [sldm_pkg::GAIN_W-1:0] turn_gain;
  logic [sldm_pkg::TRIM_W-1:0]        trim1;
  logic [sldm_pkg::TRIM_W-1:0]        trim2;
  logic [sldm_pkg::LIM_W-1:0]         cmd_lim;
  logic signed [sldm_pkg::VEL_W-1:0]  held_linear;
  logic signed [sldm_pkg::VEL_W-1:0]  held_angular;

  setpoints_t setpoint_queue[$];
  setpoints_t due;
  plan_row_t  plan[$];

  int  mismatches    = 0;
  int  words_sent    = 0;
  int  pairs_checked = 0;
  int  writes_done   = 0;
  int  settings_used = 0;
  int  quiet_cycles  = 0;
  int  busy_level    = 0;
  int  stall_left    = 0;
  bit  choke_req     = 1'b0;

  slew_limited_diff_drive_mixer_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic signed [sldm_pkg::VEL_W-1:0] slew_toward(
    logic signed [sldm_pkg::VEL_W-1:0] target,
    logic signed [sldm_pkg::VEL_W-1:0] last,
    logic [sldm_pkg::STEP_W-1:0] step);
    int diff;
    int st;
    diff = int'(target) - int'(last);
    st   = int'(step);
    if (diff > st) return sldm_pkg::VEL_W'(int'(last) + st);
    if (-diff > st) return sldm_pkg::VEL_W'(int'(last) - st);
    return target;
  endfunction

  // Product carries 34 fraction bits; round half up, then clamp to the limit.
  function automatic logic signed [sldm_pkg::SP_W-1:0] round_clamp(
    longint mixed, logic [sldm_pkg::TRIM_W-1:0] trim);
    longint p;
    longint r;
    p = mixed * longint'(trim);
    r = (p + (longint'(1) <<< (sldm_pkg::FRAC_SH - 1))) >>> sldm_pkg::FRAC_SH;
    if (r > longint'(cmd_lim)) r = longint'(cmd_lim);
    if (r < -longint'(cmd_lim)) r = -longint'(cmd_lim);
    return sldm_pkg::SP_W'(r);
  endfunction

  function automatic setpoints_t advance_mixer(logic signed [sldm_pkg::VEL_W-1:0] tl,
                                              logic signed [sldm_pkg::VEL_W-1:0] ta);
    setpoints_t sp;
    longint     base;
    longint     turn;
    held_linear  = slew_toward(tl, held_linear, lin_step);
    held_angular = slew_toward(ta, held_angular, ang_step);
    base   = longint'(fwd_gain) * longint'(held_linear);
    turn   = longint'(turn_gain) * longint'(held_angular);
    sp.ch1 = round_clamp(base - turn, trim1);
    sp.ch2 = round_clamp(base + turn, trim2);
    return sp;
  endfunction

  function automatic void apply_register(logic [sldm_pkg::CFG_A_W-1:0] addr,
                                         logic [sldm_pkg::CFG_D_W-1:0] value);
    case (addr)
      sldm_pkg::REG_LIN_STEP:  lin_step  = value[sldm_pkg::STEP_W-1:0];
      sldm_pkg::REG_ANG_STEP:  ang_step  = value[sldm_pkg::STEP_W-1:0];
      sldm_pkg::REG_FWD_GAIN:  fwd_gain  = value[sldm_pkg::GAIN_W-1:0];
      sldm_pkg::REG_TURN_GAIN: turn_gain = value[sldm_pkg::GAIN_W-1:0];
      sldm_pkg::REG_TRIM1:     trim1     = value[sldm_pkg::TRIM_W-1:0];
      sldm_pkg::REG_TRIM2:     trim2     = value[sldm_pkg::TRIM_W-1:0];
      sldm_pkg::REG_CMD_LIM:   cmd_lim   = value[sldm_pkg::LIM_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic plan_row_t cfg_row(logic [sldm_pkg::CFG_A_W-1:0] addr,
                                        logic [sldm_pkg::CFG_D_W-1:0] value);
    plan_row_t row;
    row        = '{default: '0};
    row.is_cfg = 1'b1;
    row.addr   = addr;
    row.value  = value;
    return row;
  endfunction

  function automatic plan_row_t item_row(logic signed [sldm_pkg::VEL_W-1:0] tl,
                                         logic signed [sldm_pkg::VEL_W-1:0] ta);
    plan_row_t row;
    row    = '{default: '0};
    row.tl = tl;
    row.ta = ta;
    return row;
  endfunction

  function automatic plan_row_t known_row(logic signed [sldm_pkg::VEL_W-1:0] tl,
                                          logic signed [sldm_pkg::VEL_W-1:0] ta,
                                          logic signed [sldm_pkg::SP_W-1:0] e1,
                                          logic signed [sldm_pkg::SP_W-1:0] e2);
    plan_row_t row;
    row       = item_row(tl, ta);
    row.typed = 1'b1;
    row.e1    = e1;
    row.e2    = e2;
    return row;
  endfunction

  // Targets on or just past the slew boundaries are nearly as common as fully random ones.
  function automatic logic signed [sldm_pkg::VEL_W-1:0] pick_target(
    logic signed [sldm_pkg::VEL_W-1:0] last,
    logic [sldm_pkg::STEP_W-1:0] step);
    int mode;
    int v;
    mode = $urandom_range(0, 11);
    if (mode <= 4)       v = int'($urandom_range(0, 65535)) - 32768;
    else if (mode == 5)  v = int'(last) + int'(step);
    else if (mode == 6)  v = int'(last) - int'(step);
    else if (mode == 7)  v = int'(last) + int'(step) + 1;
    else if (mode == 8)  v = int'(last) - int'(step) - 1;
    else if (mode == 9)  v = int'(last) + int'($urandom_range(0, 200)) - 100;
    else if (mode == 10) v = 32767;
    else                 v = -32768;
    if (v > 32767 || v < -32768) v = int'($urandom_range(0, 65535)) - 32768;
    return sldm_pkg::VEL_W'(v);
  endfunction

  // Style 0 gives the reset value, 1 an extreme, 2 a random legal value.
  function automatic logic [sldm_pkg::CFG_D_W-1:0] pick_setting(sldm_pkg::reg_idx_t ri,
                                                                int style);
    logic [sldm_pkg::CFG_D_W-1:0] v;
    logic [sldm_pkg::CFG_D_W-1:0] rstv;
    int                           hi;
    int                           w;
    bit                           is_gain;
    is_gain = 1'b0;
    hi      = 32767;
    w       = sldm_pkg::STEP_W;
    case (ri)
      sldm_pkg::REG_LIN_STEP:  rstv = sldm_pkg::CFG_D_W'(sldm_pkg::LIN_STEP_RST);
      sldm_pkg::REG_ANG_STEP:  rstv = sldm_pkg::CFG_D_W'(sldm_pkg::ANG_STEP_RST);
      sldm_pkg::REG_FWD_GAIN:  begin rstv = sldm_pkg::FWD_GAIN_RST;  is_gain = 1'b1; end
      sldm_pkg::REG_TURN_GAIN: begin rstv = sldm_pkg::TURN_GAIN_RST; is_gain = 1'b1; end
      sldm_pkg::REG_TRIM1: begin
        rstv = sldm_pkg::CFG_D_W'(sldm_pkg::TRIM1_RST); hi = 65535; w = sldm_pkg::TRIM_W;
      end
      sldm_pkg::REG_TRIM2: begin
        rstv = sldm_pkg::CFG_D_W'(sldm_pkg::TRIM2_RST); hi = 65535; w = sldm_pkg::TRIM_W;
      end
      default: begin
        rstv = sldm_pkg::CFG_D_W'(sldm_pkg::CMD_LIM_RST); hi = 1000; w = sldm_pkg::LIM_W;
      end
    endcase
    if (style == 0) begin
      v = rstv;
    end else if (is_gain) begin
      if (style == 1) begin
        case ($urandom_range(0, 2))
          0:       v = 20'h80000;
          1:       v = 20'h7FFFF;
          default: v = '0;
        endcase
      end else if ($urandom_range(0, 1) == 0) begin
        v = sldm_pkg::CFG_D_W'($urandom);
      end else begin
        v = sldm_pkg::CFG_D_W'($urandom_range(0, 8191) - 4096);
      end
    end else if (style == 1) begin
      if (ri == sldm_pkg::REG_CMD_LIM && $urandom_range(0, 2) == 0) v = sldm_pkg::CFG_D_W'(1023);
      else v = $urandom_range(0, 1) ? sldm_pkg::CFG_D_W'(hi) : '0;
    end else begin
      v = $urandom_range(0, 1) ? sldm_pkg::CFG_D_W'($urandom_range(0, hi))
                               : sldm_pkg::CFG_D_W'($urandom_range(0, hi / 16));
      // Bits above the register width must be dropped by the block.
      if ($urandom_range(0, 3) == 0)
        v = v | (sldm_pkg::CFG_D_W'($urandom) & ~((sldm_pkg::CFG_D_W'(1) << w) - 1));
    end
    return v;
  endfunction

  task automatic settle();
    in_tvalid = 1'b0;
    while (setpoint_queue.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_register(logic [sldm_pkg::CFG_A_W-1:0] addr,
                                logic [sldm_pkg::CFG_D_W-1:0] value);
    cfg_we    = 1'b1;
    cfg_addr  = addr;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 1'b0;
    apply_register(addr, value);
    writes_done++;
  endtask

  task automatic send_word(logic signed [sldm_pkg::VEL_W-1:0] tl,
                           logic signed [sldm_pkg::VEL_W-1:0] ta, bit typed,
                           logic signed [sldm_pkg::SP_W-1:0] e1,
                           logic signed [sldm_pkg::SP_W-1:0] e2);
    setpoints_t want;
    if (busy_level != 0 && $urandom_range(0, 9) < busy_level) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = {ta, tl};
    do @(posedge clk); while (!in_tready);
    want = advance_mixer(tl, ta);
    if (typed) begin
      want.ch1 = e1;
      want.ch2 = e2;
    end
    setpoint_queue.insert(setpoint_queue.size(), want);
    words_sent++;
    @(negedge clk);
  endtask

  // Result side: random stalls, plus one long hold-off so the block backs up.
  initial begin
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (choke_req) begin
        choke_req  = 1'b0;
        out_tready = 1'b0;
        repeat (CHOKE_CYCLES) @(negedge clk);
      end
      if (stall_left > 0) begin
        out_tready = 1'b0;
        stall_left--;
      end else if (busy_level != 0 && $urandom_range(0, 9) < busy_level) begin
        out_tready = 1'b0;
        stall_left = $urandom_range(0, 4);
      end else begin
        out_tready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      pairs_checked++;
      if (setpoint_queue.size() == 0) begin
        $error("setpoint word %h arrived with nothing pending", out_tdata);
        mismatches++;
      end else begin
        due = setpoint_queue.pop_front();
        if (out_tdata[sldm_pkg::SP_W-1:0] !== due.ch1) begin
          $error("channel1_setpoint: expected %0d, got %0d", due.ch1,
                 $signed(out_tdata[sldm_pkg::SP_W-1:0]));
          mismatches++;
        end
        if (out_tdata[2*sldm_pkg::SP_W-1:sldm_pkg::SP_W] !== due.ch2) begin
          $error("channel2_setpoint: expected %0d, got %0d", due.ch2,
                 $signed(out_tdata[2*sldm_pkg::SP_W-1:sldm_pkg::SP_W]));
          mismatches++;
        end
        if (out_tdata[sldm_pkg::OUT_TD_W-1:2*sldm_pkg::SP_W] !== '0) begin
          $error("pad: expected 0, got %0d", out_tdata[sldm_pkg::OUT_TD_W-1:2*sldm_pkg::SP_W]);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  initial begin
    sldm_pkg::reg_idx_t ri;
    int                 style;
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    cfg_we       = 1'b0;
    cfg_addr     = '0;
    cfg_wdata    = '0;
    lin_step     = sldm_pkg::LIN_STEP_RST;
    ang_step     = sldm_pkg::ANG_STEP_RST;
    fwd_gain     = sldm_pkg::FWD_GAIN_RST;
    turn_gain    = sldm_pkg::TURN_GAIN_RST;
    trim1        = sldm_pkg::TRIM1_RST;
    trim2        = sldm_pkg::TRIM2_RST;
    cmd_lim      = sldm_pkg::CMD_LIM_RST;
    held_linear  = '0;
    held_angular = '0;

    plan = '{
      known_row(0, 0, 0, 0),                 // reset state: zero velocity, zero command
      item_row(32767, -32768),               // full-scale jumps move by the reset step
      item_row(-32768, 32767),
      cfg_row(sldm_pkg::REG_LIN_STEP, 20'd0),
      cfg_row(sldm_pkg::REG_ANG_STEP, 20'd0),
      item_row(1000, -1000),                 // zero step holds the last value
      cfg_row(sldm_pkg::REG_LIN_STEP, 20'hFFFFF),
      cfg_row(sldm_pkg::REG_ANG_STEP, 20'd32767),
      item_row(32767, 32767),
      item_row(-32768, -32768),              // difference wider than the largest step
      item_row(-32768, -32768),
      item_row(-32768, -32768),
      cfg_row(sldm_pkg::REG_CMD_LIM, 20'hFFFFF),       // limit above 1000
      cfg_row(sldm_pkg::REG_FWD_GAIN, 20'h7FFFF),
      cfg_row(sldm_pkg::REG_TURN_GAIN, 20'd0),
      cfg_row(sldm_pkg::REG_TRIM1, 20'd65535),
      cfg_row(sldm_pkg::REG_TRIM2, 20'd65535),
      known_row(-32768, 0, -1023, -1023),
      item_row(32767, 0),
      known_row(32767, 0, 1023, 1023),
      cfg_row(sldm_pkg::REG_FWD_GAIN, 20'd0),
      known_row(12345, -23456, 0, 0),        // all gains zero
      cfg_row(sldm_pkg::REG_TRIM1, 20'd0),
      cfg_row(sldm_pkg::REG_TRIM2, 20'd0),
      cfg_row(sldm_pkg::REG_FWD_GAIN, 20'h80000),
      cfg_row(sldm_pkg::REG_TURN_GAIN, 20'h80000),
      known_row(-32768, 32767, 0, 0),        // trims zero
      cfg_row(sldm_pkg::REG_TRIM1, 20'd65535),
      cfg_row(sldm_pkg::REG_TRIM2, 20'd65535),
      cfg_row(sldm_pkg::REG_CMD_LIM, 20'd0),
      known_row(32767, -32768, 0, 0),        // limit zero
      cfg_row(sldm_pkg::REG_CMD_LIM, 20'd1000),
      cfg_row(sldm_pkg::REG_FWD_GAIN, 20'd256),
      cfg_row(sldm_pkg::REG_TURN_GAIN, 20'd0),
      cfg_row(sldm_pkg::REG_TRIM1, 20'd16384),
      cfg_row(sldm_pkg::REG_TRIM2, 20'd16384),
      known_row(2048, 0, 1, 1),              // exactly one half rounds up
      known_row(-2048, 0, 0, 0),             // minus one half rounds up to zero
      known_row(6144, 0, 2, 2),
      cfg_row(sldm_pkg::REG_TURN_GAIN, 20'd256),
      known_row(0, 2048, 0, 1),
      cfg_row(REG_UNUSED, 20'hFFFFF),        // write to an unused index changes nothing
      item_row(0, 2048)
    };

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    busy_level = 2;
    settings_used++;
    for (int i = 0; i < plan.size(); i++) begin
      if (plan[i].is_cfg) begin
        if (i == 0 || !plan[i-1].is_cfg) begin
          settle();
          settings_used++;
        end
        write_register(plan[i].addr, plan[i].value);
      end else begin
        send_word(plan[i].tl, plan[i].ta, plan[i].typed, plan[i].e1, plan[i].e2);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      settings_used++;
      ri = ri.first();
      do begin
        if (ph == 0 || ph == PHASES - 1) style = 0;
        else if (ph == 1) style = 1;
        else style = $urandom_range(0, 2);
        write_register(ri, pick_setting(ri, style));
        ri = ri.next();
      end while (ri != ri.first());
      if ($urandom_range(0, 2) == 0) write_register(REG_UNUSED, sldm_pkg::CFG_D_W'($urandom));
      busy_level = (ph == PHASES - 1) ? 0 : $urandom_range(0, 3);
      if (ph == 2) choke_req = 1'b1;
      repeat (WORDS_PER_PHASE)
        send_word(pick_target(held_linear, lin_step), pick_target(held_angular, ang_step),
                  1'b0, '0, '0);
    end

    in_tvalid = 1'b0;
    while (setpoint_queue.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (setpoint_queue.size() != 0) begin
      $error("%0d setpoint pairs never arrived", setpoint_queue.size());
      mismatches++;
    end

    $display("Drove %0d velocity words through %0d register settings (%0d writes).",
             words_sent, settings_used, writes_done);
    $display("Checked %0d setpoint pairs, %0d mismatches.", pairs_checked, mismatches);
    if (mismatches == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
